// ===== rtl/rwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reorder window delivery package
// Field widths, slot entry type and controller states shared by the block.
// ----------------------------------------------------------------------------
package rwd_pkg;

  localparam int SEQ_IN_W = 8;
  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 11;

  typedef logic [SEQ_IN_W-1:0] seq_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [LENGTH_W-1:0] length_t;

  typedef struct packed {
    handle_t handle;
    length_t length;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } rwd_state_t;

endpackage
`default_nettype wire

// ===== rtl/rwd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packet descriptor channel
// Valid/ready channel carrying one packet descriptor per transaction.
// ----------------------------------------------------------------------------
interface rwd_in_if;
  import rwd_pkg::*;

  logic    valid;
  logic    ready;
  seq_t    seq;
  handle_t payload_handle;
  length_t length;

  modport source (output valid, output seq, output payload_handle, output length,
                  input ready);
  modport sink   (input valid, input seq, input payload_handle, input length,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rwd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Delivery channel
// Valid/ready channel carrying one in-order delivery per transaction.
// ----------------------------------------------------------------------------
interface rwd_out_if;
  import rwd_pkg::*;

  logic    valid;
  logic    ready;
  handle_t out_handle;
  length_t out_length;
  logic    last;

  modport source (output valid, output out_handle, output out_length, output last,
                  input ready);
  modport sink   (input valid, input out_handle, input out_length, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/rwd_slot_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reorder window slot store
// One-write, one-read synchronous memory of packet handles and lengths,
// read data registered.
// ----------------------------------------------------------------------------
module rwd_slot_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  rwd_pkg::entry_t   wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output rwd_pkg::entry_t   rd_data
);
  import rwd_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/reorder_window_delivery_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reorder window delivery unit
// Receive-side reorder window: stores out-of-order packet descriptors and
// releases them in sequence order.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries packet descriptors (seq, payload_handle, length). A descriptor
//   whose slot (seq mod SEQ_SPACE mod WINDOW_SLOTS) is occupied is dropped.
//   Otherwise it is written into the slot memory and the controller walks the
//   window from the expected slot, sending every occupied slot on tx until
//   the first empty one; the final delivery of a walk has last set.
//   Timing: rx is taken only while the controller is idle. A stored
//   descriptor is written in ST_IDLE and the expected slot is checked in
//   ST_SCAN; each delivery is read from the slot memory in ST_SCAN and then
//   offered on tx in ST_OUT (held there while tx.ready is low). A duplicate
//   is dropped without leaving ST_IDLE. The slot memory has a single read
//   port and the walk goes one slot at a time, so no new descriptor is taken
//   until the walk has ended.
//   A stalled receiver holds the delivery on tx and freezes the walk.
//   Reset clears all occupancy flags and the expected sequence at once.
// ----------------------------------------------------------------------------
module reorder_window_delivery_unit #(
  parameter int WINDOW_SLOTS = 16,
  parameter int SEQ_SPACE    = 256
) (
  input  logic      clk,
  input  logic      rst,
  rwd_in_if.sink    rx,
  rwd_out_if.source tx
);
  import rwd_pkg::*;

  localparam int SLOT_W   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int SEQ_W    = $clog2(SEQ_SPACE);
  localparam int SEQ_VALS = 2 ** SEQ_IN_W;

  rwd_state_t               state;
  rwd_state_t               state_next;
  logic [WINDOW_SLOTS-1:0]  full;
  logic [SEQ_W-1:0]         exp_seq;
  logic [SEQ_W-1:0]         exp_seq_next;
  logic [SLOT_W-1:0]        exp_slot;
  logic [SLOT_W-1:0]        exp_slot_next;
  logic                     last_q;
  logic                     nxt_full;
  logic [SLOT_W-1:0]        in_slot;
  logic                     wr_en;
  logic                     rd_en;
  entry_t                   wr_data;
  entry_t                   rd_data;
  logic [SLOT_W-1:0]        slot_lut [SEQ_VALS];

  // Sequence number to window slot, worked out at elaboration.
  for (genvar v = 0; v < SEQ_VALS; v++) begin : g_slot_lut
    assign slot_lut[v] = SLOT_W'((v % SEQ_SPACE) % WINDOW_SLOTS);
  end

  assign in_slot = slot_lut[rx.seq];
  assign wr_data = '{handle: rx.payload_handle, length: rx.length};

  // Advance expected sequence; slot restarts at zero when the sequence wraps.
  always_comb begin
    if (exp_seq == SEQ_W'(SEQ_SPACE - 1)) begin
      exp_seq_next  = '0;
      exp_slot_next = '0;
    end else begin
      exp_seq_next  = exp_seq + 1'b1;
      exp_slot_next = (exp_slot == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : exp_slot + 1'b1;
    end
    // the slot being freed now counts as empty
    nxt_full = full[exp_slot_next] && (exp_slot_next != exp_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      full     <= '0;
      exp_seq  <= '0;
      exp_slot <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        full[in_slot] <= 1'b1;
      end
      if (rd_en) begin
        full[exp_slot] <= 1'b0;
        exp_seq        <= exp_seq_next;
        exp_slot       <= exp_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      last_q <= !nxt_full;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rx.ready   = (state == ST_IDLE);
    tx.valid   = (state == ST_OUT);
    unique case (state)
      ST_IDLE: begin
        // drop duplicates: occupied slot leaves everything unchanged
        if (rx.valid && !full[in_slot]) begin
          wr_en      = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (full[exp_slot]) begin
          rd_en      = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (tx.ready) begin
          state_next = last_q ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign tx.out_handle = rd_data.handle;
  assign tx.out_length = rd_data.length;
  assign tx.last       = last_q;

  rwd_slot_store #(
    .DEPTH  (WINDOW_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_slot_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_slot),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (exp_slot),
    .rd_data (rd_data)
  );

  a_store_sets_full: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && !full[in_slot]) |=> full[$past(in_slot)])
    else $error("stored descriptor did not mark its slot occupied");

  a_dup_no_change: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && full[in_slot]) |=> ($stable(full) && state == ST_IDLE))
    else $error("duplicate descriptor changed window state");

  a_delivery_frees: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && full[exp_slot] && !(WINDOW_SLOTS == 1 && 1'b0))
    |=> !full[$past(exp_slot)])
    else $error("delivered slot still occupied");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && tx.last) |=> !full[exp_slot])
    else $error("walk ended while expected slot is occupied");

endmodule
`default_nettype wire
